// File: hdl/ecgm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecgm_pkg
// Shared types and constants for the edge-clustering grid map pipeline.
// ----------------------------------------------------------------------------
package ecgm_pkg;

  localparam int DIMENSIONS = 3;

  localparam logic [2:0] REG_AXIS  = 3'd0;
  localparam logic [2:0] REG_START = 3'd1;
  localparam logic [2:0] REG_SIZE  = 3'd2;
  localparam logic [2:0] REG_BETA  = 3'd3;
  localparam logic [2:0] REG_RATIO = 3'd4;

  localparam int DIV_W      = 33;
  localparam int DIVA_STEPS = 30;
  localparam int DIVB_STEPS = 33;
  localparam int EXP_TERMS  = 12;

  localparam logic [31:0] LN2_Q32 = 32'd2977044472;

  localparam logic [33:0] RECIP_Q33 [16] = '{
    34'd0,          34'd8589934592, 34'd4294967296, 34'd2863311530,
    34'd2147483648, 34'd1717986918, 34'd1431655765, 34'd1227133513,
    34'd1073741824, 34'd954437176,  34'd858993459,  34'd780903144,
    34'd715827882,  34'd0,          34'd0,          34'd0
  };

  typedef struct packed {
    logic [2:0][31:0] coord;
    logic [1:0]       axis;
    logic             map;
    logic             qneg;
    logic             sat;
    logic [6:0]       n;
    logic             rneg;
  } side_t;

  typedef struct packed {
    logic [DIV_W-1:0] rem;
    logic [DIV_W-1:0] dend;
    logic [DIV_W-1:0] quo;
    logic [DIV_W-1:0] dvs;
  } div_t;

  typedef struct packed {
    logic [32:0]        term;
    logic signed [34:0] sum;
    logic [31:0]        y;
  } exp_t;

endpackage

// File: hdl/edge_clustering_grid_map.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edge_clustering_grid_map
// Edge-clustering stretch of one coordinate of a mesh point.
// ----------------------------------------------------------------------------
// Throughput: one request per cycle; the pipeline holds as a whole while the
// result register waits (two 30/33-step divider chains and 12 Taylor cells).
// Reset: synchronous active-low rst_n clears all valid bits and loads the
// register defaults; no clearing pass.
// ----------------------------------------------------------------------------
module edge_clustering_grid_map
  import ecgm_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_addr,
  input  logic [31:0]  cfg_wdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [95:0]  in_tdata,   // coord_x, coord_y, coord_z
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [103:0] out_tdata   // mapped_x, mapped_y, mapped_z, clipped, pad
);

  logic [1:0]  axis_r;
  logic [31:0] start_r;
  logic [30:0] size_r;
  logic [30:0] beta_r;
  logic [31:0] ratio_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_r  <= 2'd0;
      start_r <= 32'd0;
      size_r  <= 31'd65536;
      beta_r  <= 31'd131072;
      ratio_r <= 32'd26591258;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_AXIS:  axis_r  <= cfg_wdata[1:0];
        REG_START: start_r <= cfg_wdata;
        REG_SIZE:  size_r  <= cfg_wdata[30:0];
        REG_BETA:  beta_r  <= cfg_wdata[30:0];
        REG_RATIO: ratio_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic en;
  logic out_v_r;
  logic [103:0] out_d_r;

  assign en        = !out_v_r || out_tready;
  assign in_tready = en;

  // input stage
  side_t              s0;
  logic signed [34:0] q0;
  logic [31:0]        x0;
  logic [34:0]        aq0;
  logic               p1_v_r;
  side_t              p1_side_r;
  logic [32:0]        p1_aq_r;

  always_comb begin
    s0 = '0;
    for (int d = 0; d < 3; d++) begin
      s0.coord[d] = (d < DIMENSIONS) ? in_tdata[d*32 +: 32] : 32'd0;
    end
    s0.axis = axis_r;
    s0.map  = (axis_r <= 2'd2) && ({30'd0, axis_r} < DIMENSIONS);
    x0      = s0.coord[axis_r];
    q0      = $signed({4'd0, size_r}) - $signed({{3{x0[31]}}, x0})
              + $signed({{3{start_r[31]}}, start_r});
    s0.qneg = q0[34];
    aq0     = q0[34] ? (35'd0 - q0) : q0;
  end

  logic        p2_v_r;
  side_t       p2_side_r;
  logic [64:0] p2_n_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
      p2_v_r <= 1'b0;
    end else if (en) begin
      p1_v_r <= in_tvalid;
      p2_v_r <= p1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_side_r <= s0;
      p1_aq_r   <= aq0[32:0];
      p2_side_r <= p1_side_r;
      p2_n_r    <= p1_aq_r * ratio_r;
    end
  end

  // divider A: e = aq*L / size
  logic  da_v [DIVA_STEPS+1];
  side_t da_s [DIVA_STEPS+1];
  div_t  da_d [DIVA_STEPS+1];

  always_comb begin
    da_v[0]          = p2_v_r;
    da_s[0]          = p2_side_r;
    da_s[0].sat      = (p2_n_r >= {4'd0, size_r, 30'd0});
    da_d[0].rem      = {2'd0, p2_n_r[60:30]};
    da_d[0].dend     = {p2_n_r[29:0], 3'd0};
    da_d[0].quo      = '0;
    da_d[0].dvs      = {2'd0, size_r};
  end

  for (genvar i = 0; i < DIVA_STEPS; i++) begin : g_diva
    ecgm_div_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .in_v     (da_v[i]),
      .in_side  (da_s[i]),
      .in_div   (da_d[i]),
      .out_v    (da_v[i+1]),
      .out_side (da_s[i+1]),
      .out_div  (da_d[i+1])
    );
  end

  logic [30:0] emag;
  logic [55:0] fy;
  side_t       s3;
  logic        p4_v_r;
  side_t       p4_side_r;
  logic [31:0] p4_y_r;

  always_comb begin
    emag = da_s[DIVA_STEPS].sat ? 31'h4000_0000
                                : {1'b0, da_d[DIVA_STEPS].quo[29:0]};
    fy   = emag[23:0] * LN2_Q32;
    s3   = da_s[DIVA_STEPS];
    s3.n = emag[30:24];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p4_v_r <= 1'b0;
    end else if (en) begin
      p4_v_r <= da_v[DIVA_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p4_side_r <= s3;
      p4_y_r    <= fy[55:24];
    end
  end

  // Taylor series of exp(-y)
  logic  ex_v [EXP_TERMS+1];
  side_t ex_s [EXP_TERMS+1];
  exp_t  ex_d [EXP_TERMS+1];

  always_comb begin
    ex_v[0]      = p4_v_r;
    ex_s[0]      = p4_side_r;
    ex_d[0].term = 33'h1_0000_0000;
    ex_d[0].sum  = 35'sh1_0000_0000;
    ex_d[0].y    = p4_y_r;
  end

  for (genvar i = 0; i < EXP_TERMS; i++) begin : g_exp
    ecgm_exp_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .k        (4'(i + 1)),
      .in_v     (ex_v[i]),
      .in_side  (ex_s[i]),
      .in_exp   (ex_d[i]),
      .out_v    (ex_v[i+1]),
      .out_side (ex_s[i+1]),
      .out_exp  (ex_d[i+1])
    );
  end

  logic [32:0] v5;
  logic [7:0]  sh5;
  logic [32:0] vs5;
  logic        p5_v_r;
  side_t       p5_side_r;
  logic [30:0] p5_s_r;

  always_comb begin
    if (ex_d[EXP_TERMS].sum < 0) begin
      v5 = '0;
    end else if (ex_d[EXP_TERMS].sum > 35'sh1_0000_0000) begin
      v5 = 33'h1_0000_0000;
    end else begin
      v5 = ex_d[EXP_TERMS].sum[32:0];
    end
    sh5 = {1'b0, ex_s[EXP_TERMS].n} + 8'd2;
    vs5 = (sh5 >= 8'd33) ? 33'd0 : (v5 >> sh5[5:0]);
  end

  // ratio numerator and denominator
  logic signed [32:0] bp;
  logic signed [32:0] bm;
  logic signed [65:0] pm;
  logic               p6_v_r;
  side_t              p6_side_r;
  logic signed [63:0] p6_prod_r;
  logic [31:0]        p6_den_r;
  logic signed [63:0] num7;
  logic               p7_v_r;
  side_t              p7_side_r;
  logic signed [63:0] p7_num_r;
  logic [31:0]        p7_den_r;

  always_comb begin
    bp   = $signed({2'd0, beta_r}) + 33'sd65536;
    bm   = $signed({2'd0, beta_r}) - 33'sd65536;
    pm   = (p5_side_r.qneg ? bm : bp) * $signed({2'd0, p5_s_r});
    num7 = p6_side_r.qneg
         ? (($signed({{31{bp[32]}}, bp}) <<< 30) - p6_prod_r)
         : (p6_prod_r - ($signed({{31{bm[32]}}, bm}) <<< 30));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p5_v_r <= 1'b0;
      p6_v_r <= 1'b0;
      p7_v_r <= 1'b0;
    end else if (en) begin
      p5_v_r <= ex_v[EXP_TERMS];
      p6_v_r <= p5_v_r;
      p7_v_r <= p6_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p5_side_r <= ex_s[EXP_TERMS];
      p5_s_r    <= vs5[30:0];
      p6_side_r <= p5_side_r;
      p6_prod_r <= pm[63:0];
      p6_den_r  <= 32'h4000_0000 + {1'b0, p5_s_r};
      p7_side_r <= p6_side_r;
      p7_num_r  <= num7;
      p7_den_r  <= p6_den_r;
    end
  end

  // divider B: r = num / den
  logic  db_v [DIVB_STEPS+1];
  side_t db_s [DIVB_STEPS+1];
  div_t  db_d [DIVB_STEPS+1];
  logic [63:0] mag7;

  always_comb begin
    mag7         = p7_num_r[63] ? (64'd0 - p7_num_r) : p7_num_r;
    db_v[0]      = p7_v_r;
    db_s[0]      = p7_side_r;
    db_s[0].rneg = p7_num_r[63];
    db_d[0].rem  = {3'd0, mag7[62:33]};
    db_d[0].dend = mag7[32:0];
    db_d[0].quo  = '0;
    db_d[0].dvs  = {1'b0, p7_den_r};
  end

  for (genvar i = 0; i < DIVB_STEPS; i++) begin : g_divb
    ecgm_div_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .in_v     (db_v[i]),
      .in_side  (db_s[i]),
      .in_div   (db_d[i]),
      .out_v    (db_v[i+1]),
      .out_side (db_s[i+1]),
      .out_div  (db_d[i+1])
    );
  end

  // scale, offset, saturate
  logic signed [33:0] r8;
  logic signed [65:0] pr8;
  logic               p8_v_r;
  side_t              p8_side_r;
  logic signed [65:0] p8_prod_r;
  logic signed [65:0] rnd9;
  logic signed [49:0] t9;
  logic signed [50:0] res9;
  logic [31:0]        val9;
  logic               clip9;
  logic [2:0][31:0]   oc9;

  always_comb begin
    r8   = db_s[DIVB_STEPS].rneg ? (34'sd0 - $signed({1'b0, db_d[DIVB_STEPS].quo}))
                                 : $signed({1'b0, db_d[DIVB_STEPS].quo});
    pr8  = $signed({1'b0, size_r}) * r8;
    rnd9 = p8_prod_r + (p8_prod_r[65] ? 66'sd65535 : 66'sd0);
    t9   = 50'(rnd9 >>> 16);
    res9 = $signed({{19{start_r[31]}}, start_r}) + $signed({t9[49], t9});
    clip9 = 1'b0;
    if (res9 > 51'sd2147483647) begin
      val9  = 32'h7FFF_FFFF;
      clip9 = 1'b1;
    end else if (res9 < -51'sd2147483648) begin
      val9  = 32'h8000_0000;
      clip9 = 1'b1;
    end else begin
      val9 = res9[31:0];
    end
    oc9 = p8_side_r.coord;
    if (p8_side_r.map) begin
      oc9[p8_side_r.axis] = val9;
    end else begin
      clip9 = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p8_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else if (en) begin
      p8_v_r  <= db_v[DIVB_STEPS];
      out_v_r <= p8_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p8_side_r <= db_s[DIVB_STEPS];
      p8_prod_r <= pr8;
      out_d_r   <= {7'd0, clip9, oc9[2], oc9[1], oc9[0]};
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_d_r;

endmodule

// File: hdl/ecgm_div_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecgm_div_cell
// One restoring division step: shift in a dividend bit, trial subtract.
// ----------------------------------------------------------------------------
module ecgm_div_cell
  import ecgm_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  logic  in_v,
  input  side_t in_side,
  input  div_t  in_div,
  output logic  out_v,
  output side_t out_side,
  output div_t  out_div
);

  logic             v_r;
  side_t            side_r;
  div_t             div_r;
  div_t             div_nxt;
  logic [DIV_W-1:0] trial;
  logic             ge;

  always_comb begin
    trial            = {in_div.rem[DIV_W-2:0], in_div.dend[DIV_W-1]};
    ge               = (trial >= in_div.dvs);
    div_nxt.rem      = ge ? (trial - in_div.dvs) : trial;
    div_nxt.dend     = {in_div.dend[DIV_W-2:0], 1'b0};
    div_nxt.quo      = {in_div.quo[DIV_W-2:0], ge};
    div_nxt.dvs      = in_div.dvs;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r <= in_side;
      div_r  <= div_nxt;
    end
  end

  assign out_v    = v_r;
  assign out_side = side_r;
  assign out_div  = div_r;

endmodule

// File: hdl/ecgm_exp_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecgm_exp_cell
// One Taylor term of exp(-y): term*y, divide by k, accumulate with sign.
// ----------------------------------------------------------------------------
module ecgm_exp_cell
  import ecgm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       en,
  input  logic [3:0] k,
  input  logic       in_v,
  input  side_t      in_side,
  input  exp_t       in_exp,
  output logic       out_v,
  output side_t      out_side,
  output exp_t       out_exp
);

  logic        a_v_r, b_v_r, o_v_r;
  side_t       a_side_r, b_side_r, o_side_r;
  exp_t        a_exp_r, b_exp_r, o_exp_r;
  logic [31:0] a_d_r, b_d_r, b_qe_r;
  logic [64:0] ty;
  logic [65:0] dm;
  logic [35:0] qk;
  logic [31:0] rem;
  logic [32:0] term;
  exp_t        exp_nxt;

  always_comb begin
    ty   = in_exp.term * in_exp.y;
    dm   = a_d_r * RECIP_Q33[k];
    qk   = b_qe_r * k;
    rem  = b_d_r - qk[31:0];
    term = {1'b0, b_qe_r} + {32'd0, (rem >= {28'd0, k})};
    exp_nxt.term = term;
    exp_nxt.y    = b_exp_r.y;
    exp_nxt.sum  = k[0] ? (b_exp_r.sum - $signed({2'b0, term}))
                        : (b_exp_r.sum + $signed({2'b0, term}));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      o_v_r <= 1'b0;
    end else if (en) begin
      a_v_r <= in_v;
      b_v_r <= a_v_r;
      o_v_r <= b_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_side_r <= in_side;
      a_exp_r  <= in_exp;
      a_d_r    <= ty[63:32];
      b_side_r <= a_side_r;
      b_exp_r  <= a_exp_r;
      b_d_r    <= a_d_r;
      b_qe_r   <= dm[64:33];
      o_side_r <= b_side_r;
      o_exp_r  <= exp_nxt;
    end
  end

  assign out_v    = o_v_r;
  assign out_side = o_side_r;
  assign out_exp  = o_exp_r;

endmodule

// File: tb/sv/tb_edge_clustering_grid_map.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_edge_clustering_grid_map
// Self-checking bench for the edge-clustering grid stretch pipeline. A short
// table of directed points, each under its own register setting, is followed
// by random phases, each with a fresh setting. Every accepted request is
// predicted by a local fixed-point model of the stretch (pass rows: a stored
// value) and compared field by field with the result stream. The sender runs
// in bursts with random gaps and the receiver stalls on a pattern of its own.
// ----------------------------------------------------------------------------
module tb_edge_clustering_grid_map;
  import ecgm_pkg::*;

  localparam int  DRAIN_CYCLES = 120;
  localparam int  IDLE_LIMIT   = 4000;
  localparam int  RAND_PHASES  = 29;
  localparam int  PHASE_POINTS = 50;
  localparam longint unsigned LN2_FRAC = 64'd2977044472;
  localparam longint ONE_Q30 = 64'sd1 << 30;

  typedef struct packed {
    logic [31:0] mz;
    logic [31:0] my;
    logic [31:0] mx;
    logic        clipped;
  } mapped_t;

  typedef struct {
    logic [95:0] data;
    bit          fixed;
    mapped_t     want;
  } point_t;

  typedef struct {
    logic [1:0]  axis;
    logic [31:0] start;
    logic [31:0] size;
    logic [31:0] beta;
    logic [31:0] ratio;
  } setting_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         cfg_we = 1'b0;
  logic [2:0]   cfg_addr = REG_AXIS;
  logic [31:0]  cfg_wdata = '0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [95:0]  in_tdata = '0;   // coord_x, coord_y, coord_z
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [103:0] out_tdata;       // mapped_x, mapped_y, mapped_z, clipped, pad

  edge_clustering_grid_map DUT (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  logic [1:0]  cur_axis;
  logic [31:0] cur_start;
  logic [30:0] cur_size;
  logic [30:0] cur_beta;
  logic [31:0] cur_ratio;

  point_t  point_q[$];
  mapped_t mapped_q[$];
  int errors = 0;
  int sent = 0;
  int results = 0;
  int clips = 0;
  int burst_left = 0;
  int gap_left = 0;
  int seg_left = 0;
  int seg_mode = 0;
  int idle = 0;

  function automatic longint unsigned exp2_frac_neg(longint unsigned f);
    longint unsigned y, term;
    longint sum;
    y = (f * LN2_FRAC) >> 24;
    term = 64'd1 << 32;
    sum = longint'(term);
    for (int k = 1; k <= 12; k++) begin
      term = ((term * y) >> 32) / longint'(k);
      if (k % 2 == 1) sum -= longint'(term);
      else sum += longint'(term);
    end
    if (sum < 0) sum = 0;
    if (sum > (64'sd1 << 32)) sum = 64'sd1 << 32;
    return longint'(sum);
  endfunction

  function automatic logic [32:0] stretch_coord(logic [31:0] xin);
    longint size, st, x, q, res, bp, bm, num, den, r;
    longint unsigned aq, emag, n, v, s, lim, thr, lr;
    logic clip;
    size = longint'(cur_size);
    st = $signed(cur_start);
    x = $signed(xin);
    lr = longint'(cur_ratio);
    clip = 1'b0;
    if (size == 0) begin
      res = st;
    end else begin
      q = size - (x - st);
      aq = (q < 0) ? longint'(-q) : longint'(q);
      emag = 0;
      if (lr != 0) begin
        lim = longint'(size) << 30;
        thr = (lim + lr - 1) / lr;
        if (aq >= thr) emag = 64'd1 << 30;
        else emag = (aq * lr) / longint'(size);
      end
      n = emag >> 24;
      v = exp2_frac_neg(emag & 64'hFFFFFF);
      s = (n + 2 >= 63) ? 0 : (v >> (n + 2));
      bp = longint'(cur_beta) + 65536;
      bm = longint'(cur_beta) - 65536;
      if (q >= 0) num = bp * longint'(s) - bm * ONE_Q30;
      else num = bp * ONE_Q30 - bm * longint'(s);
      den = ONE_Q30 + longint'(s);
      r = num / den;
      res = st + (size * r) / 65536;
    end
    if (res > 64'sd2147483647) begin
      res = 64'sd2147483647;
      clip = 1'b1;
    end else if (res < -64'sd2147483648) begin
      res = -64'sd2147483648;
      clip = 1'b1;
    end
    return {clip, res[31:0]};
  endfunction

  function automatic mapped_t map_point(logic [95:0] d);
    logic [2:0][31:0] c;
    logic [32:0] sr;
    mapped_t m;
    c = d;
    m.clipped = 1'b0;
    if (cur_axis <= 2 && int'(cur_axis) < DIMENSIONS) begin
      sr = stretch_coord(c[cur_axis]);
      c[cur_axis] = sr[31:0];
      m.clipped = sr[32];
    end
    m.mx = c[0];
    m.my = c[1];
    m.mz = c[2];
    return m;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("result %0d: %s got %h want %h", results, what, got, want);
    errors++;
  endtask

  // sender: bursts with gaps, hold while stalled
  always @(posedge clk) begin
    logic nv;
    nv = 1'b0;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        if (point_q[0].fixed) mapped_q.push_back(point_q[0].want);
        else mapped_q.push_back(map_point(in_tdata));
        point_q.pop_front();
        sent++;
      end
      if (in_tvalid && !in_tready) begin
        nv = 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
      end else if (point_q.size() > 0) begin
        nv = 1'b1;
        if (burst_left == 0) burst_left = $urandom_range(1, 40);
        burst_left--;
        if (burst_left == 0) gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      end
      in_tvalid <= nv;
      if (nv) in_tdata <= point_q[0].data;
    end
  end

  // receiver stall pattern
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (seg_left == 0) begin
        seg_mode = $urandom_range(0, 2);
        seg_left = $urandom_range(10, 200);
      end
      seg_left--;
      case (seg_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= 1'($urandom_range(0, 1));
        default: out_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    mapped_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata[95:0], out_tdata[96]};
      if (got.clipped) clips++;
      if (mapped_q.size() == 0) begin
        $display("result %0d: no request outstanding", results);
        errors++;
      end else begin
        want = mapped_q.pop_front();
        if (got.mx !== want.mx) report_mismatch("mapped_x", got.mx, want.mx);
        if (got.my !== want.my) report_mismatch("mapped_y", got.my, want.my);
        if (got.mz !== want.mz) report_mismatch("mapped_z", got.mz, want.mz);
        if (got.clipped !== want.clipped)
          report_mismatch("clipped", 32'(got.clipped), 32'(want.clipped));
      end
      results++;
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle = 0;
    else idle++;
    if (idle >= IDLE_LIMIT) begin
      $display("timeout: no request moved for %0d cycles", IDLE_LIMIT);
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic drain();
    while (point_q.size() != 0 || in_tvalid || mapped_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic load_setting(setting_t st);
    logic [2:0]  addr [5];
    logic [31:0] val [5];
    addr = '{REG_AXIS, REG_START, REG_SIZE, REG_BETA, REG_RATIO};
    val = '{32'(st.axis), st.start, st.size, st.beta, st.ratio};
    drain();
    for (int i = 0; i < 5; i++) begin
      @(posedge clk);
      cfg_we <= 1'b1;
      cfg_addr <= addr[i];
      cfg_wdata <= val[i];
    end
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_axis = st.axis;
    cur_start = st.start;
    cur_size = st.size[30:0];
    cur_beta = st.beta[30:0];
    cur_ratio = st.ratio;
  endtask

  function automatic point_t make_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    point_t p;
    p.data = {z, y, x};
    p.fixed = 1'b0;
    p.want = '0;
    return p;
  endfunction

  function automatic point_t pass_point(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                        logic [31:0] wx);
    point_t p;
    p = make_point(x, y, z);
    p.fixed = 1'b1;
    p.want = '{mz: z, my: y, mx: wx, clipped: 1'b0};
    return p;
  endfunction

  setting_t dir_cfg [$];
  point_t   dir_pt [$];

  task automatic add_row(setting_t st, point_t p);
    dir_cfg.push_back(st);
    dir_pt.push_back(p);
  endtask

  function automatic logic [31:0] pick_start();
    case ($urandom_range(0, 5))
      0: return 32'h0;
      1: return 32'h7FFFFFFF;
      2: return 32'h80000000;
      3: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_size();
    case ($urandom_range(0, 9)) inside
      0: return 32'h7FFFFFFF;
      1: return 32'd1;
      2: return 32'h0;
      [3:4]: return $urandom_range(1, 32'h7FFFFFFF);
      default: return $urandom_range(1, 32'h0010_0000);
    endcase
  endfunction

  function automatic logic [31:0] pick_beta();
    case ($urandom_range(0, 7))
      0: return 32'h7FFFFFFF;
      1: return $urandom_range(0, 65536);
      2: return 32'd65537;
      default: return $urandom_range(65537, 65536 * 64);
    endcase
  endfunction

  function automatic logic [31:0] pick_ratio();
    case ($urandom_range(0, 7))
      0: return 32'h0;
      1: return 32'hFFFFFFFF;
      2: return $urandom;
      default: return $urandom_range(0, 32'h1000_0000);
    endcase
  endfunction

  initial begin
    setting_t dflt, st;
    logic [31:0] c [3];
    int nphase;
    nphase = 0;
    dflt = '{axis: 2'd0, start: 32'd0, size: 32'd65536, beta: 32'd131072,
             ratio: 32'd26591258};
    cur_axis = dflt.axis;
    cur_start = dflt.start;
    cur_size = dflt.size[30:0];
    cur_beta = dflt.beta[30:0];
    cur_ratio = dflt.ratio;

    // directed rows; the first few run on the reset defaults
    add_row(dflt, make_point(32'h0, 32'h1, 32'hFFFFFFFF));
    add_row(dflt, make_point(32'h10000, 32'h7FFFFFFF, 32'h80000000));
    add_row(dflt, make_point(32'h7FFFFFFF, 32'h80000000, 32'h0));
    add_row(dflt, make_point(32'h80000000, 32'hFFFFFFFF, 32'h7FFFFFFF));
    st = dflt; st.axis = 2'd1;
    add_row(st, make_point(32'h1234, 32'h8000, 32'h5678));
    st = dflt; st.axis = 2'd2;
    add_row(st, make_point(32'hAAAA5555, 32'h5555AAAA, 32'hC000));
    st = dflt; st.axis = 2'd3;
    add_row(st, pass_point(32'hDEADBEEF, 32'h01234567, 32'h89ABCDEF, 32'hDEADBEEF));
    st = dflt; st.size = 32'd0; st.start = 32'd12345;
    add_row(st, pass_point(32'h7FFFFFFF, 32'h1, 32'h2, 32'd12345));
    st.start = 32'h80000000;
    add_row(st, pass_point(32'h0, 32'hFFFFFFFF, 32'h0, 32'h80000000));
    st = dflt; st.beta = 32'd65536;
    add_row(st, make_point(32'h4000, 32'h0, 32'h0));
    st.beta = 32'd0;
    add_row(st, make_point(32'hC000, 32'h0, 32'h0));
    st.beta = 32'h7FFFFFFF;
    add_row(st, make_point(32'h8000, 32'h0, 32'h0));
    st = dflt; st.ratio = 32'hFFFFFFFF;
    add_row(st, make_point(32'h80000000, 32'h0, 32'h0));
    add_row(st, make_point(32'h7FFFFFFF, 32'h0, 32'h0));
    st.ratio = 32'h0;
    add_row(st, make_point(32'h9000, 32'h0, 32'h0));
    st = '{axis: 2'd0, start: 32'h7FFFFFFF, size: 32'h7FFFFFFF, beta: 32'h7FFFFFFF,
           ratio: 32'h0100_0000};
    add_row(st, make_point(32'h80000000, 32'h0, 32'h0));
    st.start = 32'h80000000;
    add_row(st, make_point(32'h7FFFFFFF, 32'h0, 32'h0));
    st = dflt; st.size = 32'd1;
    add_row(st, make_point(32'h0, 32'h0, 32'h0));
    st = dflt; st.size = 32'hFFFFFFFF; st.beta = 32'hFFFFFFFF;
    add_row(st, make_point(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF));

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_pt[i]) begin
      if (i > 0) load_setting(dir_cfg[i]);
      point_q.push_back(dir_pt[i]);
    end

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      st.axis = 2'($urandom_range(0, 3));
      st.start = pick_start();
      st.size = pick_size();
      st.beta = pick_beta();
      st.ratio = pick_ratio();
      load_setting(st);
      nphase++;
      for (int i = 0; i < PHASE_POINTS; i++) begin
        c = '{$urandom, $urandom, $urandom};
        if (st.axis != 2'd3 && $urandom_range(0, 3) != 0)
          c[st.axis] = st.start + $urandom_range(0, st.size[30:0]);
        point_q.push_back(make_point(c[0], c[1], c[2]));
      end
    end

    drain();
    $display("covered %0d points over %0d directed and %0d random settings",
             sent, dir_pt.size(), nphase);
    $display("%0d results checked, %0d of them saturated", results, clips);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
